>>> rtl/typed_id_allocator_ghost_fifo_assert.svh
// Assertion macros shared by the ID allocator RTL.
`ifndef TYPED_ID_ALLOCATOR_GHOST_FIFO_ASSERT_SVH
`define TYPED_ID_ALLOCATOR_GHOST_FIFO_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define TIA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that one condition implies another in the same cycle.
`define TIA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/tia_pkg.sv
// Package with the types and constants of the typed ID allocator.
`default_nettype none

package tia_pkg;

    localparam int MAX_INSTANCES = 1024;
    localparam int MAX_TYPES     = 16;
    localparam int GHOST_DEPTH   = 256;

    localparam int ID_W    = 10;
    localparam int TYPE_W  = 4;
    localparam int HEAD_W  = 8;
    localparam int FILL_W  = 9;
    localparam int CNT_W   = 11;
    localparam int GADDR_W = TYPE_W + HEAD_W;
    localparam int SLOT_W  = 2 + TYPE_W;

    typedef enum logic [2:0] {
        MODE_CREATE    = 3'd0,
        MODE_CREATE_ID = 3'd1,
        MODE_DELETE    = 3'd2,
        MODE_RESTORE   = 3'd3,
        MODE_PURGE     = 3'd4,
        MODE_RESERVE   = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_UNKNOWN  = 3'd1,
        ST_TAKEN    = 3'd2,
        ST_WRONG    = 3'd3,
        ST_NO_SPACE = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        REG_TEMPLATE_COUNT  = 1'd0,
        REG_MAX_GHOSTS_KEPT = 1'd1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_CREATE,
        S_CHECK,
        S_RS_RD,
        S_RS_WR,
        S_PG_SCAN,
        S_PG_WR,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

>>> rtl/typed_id_allocator_ghost_fifo.sv
// Top level of the typed instance ID allocator with per-type ghost FIFOs.
//
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   mode, template_id, instance_id, keep_limit
// out      output     out_valid/out_stall status, result_id, recycled, counts
// cfg      input      cfg_we              cfg_index, cfg_data
//
// After reset a clearing pass writes all 1024 slot entries.
// Create, create with ID, delete and reserve pass through S_EXEC, then S_CREATE or S_CHECK where needed, then S_DONE.
// Restore reads each entry of the type's ghost FIFO and writes back all but the restored ID.
// Purge scans every type and frees ghost IDs until each type's fill is within the keep limit.
// A stalled result waits in the output register while the next transaction is taken.
`default_nettype none

module typed_id_allocator_ghost_fifo (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic                      cfg_index,
    input  wire logic [8:0]                cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [2:0]                mode,
    input  wire logic [tia_pkg::TYPE_W-1:0] template_id,
    input  wire logic [tia_pkg::ID_W-1:0]  instance_id,
    input  wire logic signed [9:0]         keep_limit,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [2:0]                     status,
    output logic [tia_pkg::ID_W-1:0]       result_id,
    output logic                           recycled,
    output logic [tia_pkg::CNT_W-1:0]      type_active_count,
    output logic [tia_pkg::FILL_W-1:0]     type_ghost_count,
    output logic [tia_pkg::CNT_W-1:0]      purged_count,
    output logic [tia_pkg::CNT_W-1:0]      total_active,
    output logic [tia_pkg::CNT_W-1:0]      peak_active
);
    import tia_pkg::*;

    state_t state_reg, state_next;

    logic [4:0]        tcount_reg;
    logic [8:0]        mgk_reg;
    logic [2:0]        mode_reg;
    logic [TYPE_W-1:0] tin_reg;
    logic [ID_W-1:0]   id_reg;
    logic [9:0]        keep_reg;

    logic [TYPE_W-1:0] t_reg, t_next;
    logic [ID_W-1:0]   cnt_reg, cnt_next;
    logic [FILL_W-1:0] w_reg, w_next;
    status_t           stat_reg, stat_next;
    logic [ID_W-1:0]   rid_reg, rid_next;
    logic              rec_reg, rec_next;
    logic [CNT_W-1:0]  purged_reg, purged_next;
    logic [CNT_W-1:0]  fresh_reg, fresh_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  peak_reg, peak_next;

    logic [HEAD_W-1:0] head_reg [MAX_TYPES];
    logic [HEAD_W-1:0] head_next [MAX_TYPES];
    logic [FILL_W-1:0] fill_reg [MAX_TYPES];
    logic [FILL_W-1:0] fill_next [MAX_TYPES];
    logic [CNT_W-1:0]  tact_reg [MAX_TYPES];
    logic [CNT_W-1:0]  tact_next [MAX_TYPES];

    logic [SLOT_W-1:0] slot_mem [MAX_INSTANCES];
    logic              slot_we;
    logic [ID_W-1:0]   slot_waddr, slot_raddr;
    logic [SLOT_W-1:0] slot_wdata, slot_q;

    logic [ID_W-1:0]    ghost_mem [MAX_TYPES * GHOST_DEPTH];
    logic               g_we;
    logic [GADDR_W-1:0] g_waddr, g_raddr;
    logic [ID_W-1:0]    g_wdata, g_q;

    logic              out_valid_reg;
    logic [2:0]        o_status_reg;
    logic [ID_W-1:0]   o_rid_reg;
    logic              o_rec_reg;
    logic [CNT_W-1:0]  o_tact_reg;
    logic [FILL_W-1:0] o_fill_reg;
    logic [CNT_W-1:0]  o_purged_reg;
    logic [CNT_W-1:0]  o_total_reg;
    logic [CNT_W-1:0]  o_peak_reg;

    logic              accept, done_fire, tvalid;
    logic              s_exists, s_active;
    logic [TYPE_W-1:0] s_type;
    logic [9:0]        limit;
    logic [CNT_W-1:0]  id_plus1;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign done_fire = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign tvalid    = ({1'b0, tin_reg} < tcount_reg);
    assign s_exists  = slot_q[SLOT_W-1];
    assign s_active  = slot_q[SLOT_W-2];
    assign s_type    = slot_q[TYPE_W-1:0];
    assign limit     = keep_reg[9] ? {1'b0, mgk_reg} : keep_reg;
    assign id_plus1  = {1'b0, id_reg} + CNT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (cnt_reg == ID_W'(MAX_INSTANCES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (mode_reg)
                    MODE_CREATE:
                    begin
                        if (tvalid && fill_reg[t_reg] != '0)
                        begin
                            state_next = S_CREATE;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    MODE_CREATE_ID:
                    begin
                        state_next = tvalid ? S_CHECK : S_DONE;
                    end
                    MODE_DELETE, MODE_RESTORE:
                    begin
                        state_next = S_CHECK;
                    end
                    MODE_PURGE:
                    begin
                        state_next = S_PG_SCAN;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_CREATE:
            begin
                state_next = S_DONE;
            end
            S_CHECK:
            begin
                if (mode_reg == MODE_RESTORE && s_exists && !s_active)
                begin
                    state_next = S_RS_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RS_RD:
            begin
                state_next = (cnt_reg < {1'b0, fill_reg[t_reg]}) ? S_RS_WR : S_DONE;
            end
            S_RS_WR:
            begin
                state_next = S_RS_RD;
            end
            S_PG_SCAN:
            begin
                if ({1'b0, fill_reg[t_reg]} > limit)
                begin
                    state_next = S_PG_WR;
                end
                else if (t_reg == TYPE_W'(MAX_TYPES - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_PG_WR:
            begin
                state_next = S_PG_SCAN;
            end
            S_DONE:
            begin
                if (done_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        t_next      = t_reg;
        cnt_next    = cnt_reg;
        w_next      = w_reg;
        stat_next   = stat_reg;
        rid_next    = rid_reg;
        rec_next    = rec_reg;
        purged_next = purged_reg;
        fresh_next  = fresh_reg;
        total_next  = total_reg;
        peak_next   = peak_reg;
        head_next   = head_reg;
        fill_next   = fill_reg;
        tact_next   = tact_reg;
        slot_we     = 1'b0;
        slot_waddr  = id_reg;
        slot_wdata  = '0;
        slot_raddr  = id_reg;
        g_we        = 1'b0;
        g_waddr     = '0;
        g_wdata     = id_reg;
        g_raddr     = {t_reg, head_reg[t_reg]};
        unique case (state_reg)
            S_CLEAR:
            begin
                slot_we    = 1'b1;
                slot_waddr = cnt_reg;
                cnt_next   = cnt_reg + ID_W'(1);
            end
            S_IDLE:
            begin
                t_next      = template_id;
                stat_next   = ST_OK;
                rid_next    = '0;
                rec_next    = 1'b0;
                purged_next = '0;
            end
            S_EXEC:
            begin
                case (mode_reg)
                    MODE_CREATE:
                    begin
                        if (!tvalid)
                        begin
                            stat_next = ST_UNKNOWN;
                        end
                        else if (fill_reg[t_reg] != '0)
                        begin
                            g_raddr = {t_reg, head_reg[t_reg]};
                        end
                        else if (fresh_reg < CNT_W'(MAX_INSTANCES))
                        begin
                            rid_next          = fresh_reg[ID_W-1:0];
                            fresh_next        = fresh_reg + CNT_W'(1);
                            slot_we           = 1'b1;
                            slot_waddr        = fresh_reg[ID_W-1:0];
                            slot_wdata        = {2'b11, t_reg};
                            tact_next[t_reg]  = tact_reg[t_reg] + CNT_W'(1);
                            total_next        = total_reg + CNT_W'(1);
                            if (total_reg + CNT_W'(1) > peak_reg)
                            begin
                                peak_next = total_reg + CNT_W'(1);
                            end
                        end
                        else
                        begin
                            stat_next = ST_NO_SPACE;
                        end
                    end
                    MODE_CREATE_ID:
                    begin
                        rid_next   = id_reg;
                        slot_raddr = id_reg;
                        if (!tvalid)
                        begin
                            stat_next = ST_UNKNOWN;
                        end
                    end
                    MODE_DELETE, MODE_RESTORE:
                    begin
                        rid_next   = id_reg;
                        slot_raddr = id_reg;
                    end
                    MODE_PURGE:
                    begin
                        t_next = '0;
                    end
                    MODE_RESERVE:
                    begin
                        rid_next = id_reg;
                        if ({1'b0, id_reg} > fresh_reg)
                        begin
                            fresh_next = {1'b0, id_reg};
                        end
                    end
                    default:
                    begin
                        stat_next = ST_WRONG;
                    end
                endcase
            end
            S_CREATE:
            begin
                rid_next         = g_q;
                rec_next         = 1'b1;
                head_next[t_reg] = head_reg[t_reg] + HEAD_W'(1);
                fill_next[t_reg] = fill_reg[t_reg] - FILL_W'(1);
                slot_we          = 1'b1;
                slot_waddr       = g_q;
                slot_wdata       = {2'b11, t_reg};
                tact_next[t_reg] = tact_reg[t_reg] + CNT_W'(1);
                total_next       = total_reg + CNT_W'(1);
                if (total_reg + CNT_W'(1) > peak_reg)
                begin
                    peak_next = total_reg + CNT_W'(1);
                end
            end
            S_CHECK:
            begin
                case (mode_reg)
                    MODE_CREATE_ID:
                    begin
                        if (s_exists)
                        begin
                            stat_next = ST_TAKEN;
                        end
                        else
                        begin
                            if (fresh_reg < id_plus1)
                            begin
                                fresh_next = id_plus1;
                            end
                            slot_we          = 1'b1;
                            slot_wdata       = {2'b11, t_reg};
                            tact_next[t_reg] = tact_reg[t_reg] + CNT_W'(1);
                            total_next       = total_reg + CNT_W'(1);
                        end
                    end
                    MODE_DELETE:
                    begin
                        if (!(s_exists && s_active))
                        begin
                            stat_next = ST_WRONG;
                        end
                        else
                        begin
                            t_next = s_type;
                            if (fill_reg[s_type] >= FILL_W'(GHOST_DEPTH))
                            begin
                                stat_next = ST_NO_SPACE;
                            end
                            else
                            begin
                                slot_we           = 1'b1;
                                slot_wdata        = {2'b10, s_type};
                                g_we              = 1'b1;
                                g_waddr           = {s_type, head_reg[s_type]
                                                     + fill_reg[s_type][HEAD_W-1:0]};
                                fill_next[s_type] = fill_reg[s_type] + FILL_W'(1);
                                if (tact_reg[s_type] != '0)
                                begin
                                    tact_next[s_type] = tact_reg[s_type] - CNT_W'(1);
                                end
                                if (total_reg != '0)
                                begin
                                    total_next = total_reg - CNT_W'(1);
                                end
                            end
                        end
                    end
                    default:
                    begin
                        if (!(s_exists && !s_active))
                        begin
                            stat_next = ST_WRONG;
                        end
                        else
                        begin
                            t_next   = s_type;
                            cnt_next = '0;
                            w_next   = '0;
                        end
                    end
                endcase
            end
            S_RS_RD:
            begin
                if (cnt_reg < {1'b0, fill_reg[t_reg]})
                begin
                    g_raddr = {t_reg, head_reg[t_reg] + cnt_reg[HEAD_W-1:0]};
                end
                else
                begin
                    fill_next[t_reg] = w_reg;
                    slot_we          = 1'b1;
                    slot_wdata       = {2'b11, t_reg};
                    tact_next[t_reg] = tact_reg[t_reg] + CNT_W'(1);
                    total_next       = total_reg + CNT_W'(1);
                end
            end
            S_RS_WR:
            begin
                if (g_q != id_reg)
                begin
                    g_we    = 1'b1;
                    g_waddr = {t_reg, head_reg[t_reg] + w_reg[HEAD_W-1:0]};
                    g_wdata = g_q;
                    w_next  = w_reg + FILL_W'(1);
                end
                cnt_next = cnt_reg + ID_W'(1);
            end
            S_PG_SCAN:
            begin
                if ({1'b0, fill_reg[t_reg]} > limit)
                begin
                    g_raddr = {t_reg, head_reg[t_reg]};
                end
                else if (t_reg == TYPE_W'(MAX_TYPES - 1))
                begin
                    t_next = tin_reg;
                end
                else
                begin
                    t_next = t_reg + TYPE_W'(1);
                end
            end
            S_PG_WR:
            begin
                slot_we          = 1'b1;
                slot_waddr       = g_q;
                slot_wdata       = '0;
                head_next[t_reg] = head_reg[t_reg] + HEAD_W'(1);
                fill_next[t_reg] = fill_reg[t_reg] - FILL_W'(1);
                purged_next      = purged_reg + CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            tcount_reg    <= '0;
            mgk_reg       <= 9'(GHOST_DEPTH);
            cnt_reg       <= '0;
            t_reg         <= '0;
            fresh_reg     <= '0;
            total_reg     <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_TYPES; i++)
            begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
                tact_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            t_reg     <= t_next;
            fresh_reg <= fresh_next;
            total_reg <= total_next;
            peak_reg  <= peak_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            tact_reg  <= tact_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TEMPLATE_COUNT:  tcount_reg <= cfg_data[4:0];
                    REG_MAX_GHOSTS_KEPT: mgk_reg    <= cfg_data;
                    default:             mgk_reg    <= mgk_reg;
                endcase
            end
            if (done_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
            tin_reg  <= template_id;
            id_reg   <= instance_id;
            keep_reg <= keep_limit;
        end
        w_reg      <= w_next;
        stat_reg   <= stat_next;
        rid_reg    <= rid_next;
        rec_reg    <= rec_next;
        purged_reg <= purged_next;
        if (done_fire)
        begin
            o_status_reg <= stat_reg;
            o_rid_reg    <= rid_reg;
            o_rec_reg    <= rec_reg;
            o_tact_reg   <= tact_reg[t_reg];
            o_fill_reg   <= fill_reg[t_reg];
            o_purged_reg <= purged_reg;
            o_total_reg  <= total_reg;
            o_peak_reg   <= peak_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_q <= slot_mem[slot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (g_we)
        begin
            ghost_mem[g_waddr] <= g_wdata;
        end
        g_q <= ghost_mem[g_raddr];
    end

    assign out_valid         = out_valid_reg;
    assign status            = o_status_reg;
    assign result_id         = o_rid_reg;
    assign recycled          = o_rec_reg;
    assign type_active_count = o_tact_reg;
    assign type_ghost_count  = o_fill_reg;
    assign purged_count      = o_purged_reg;
    assign total_active      = o_total_reg;
    assign peak_active       = o_peak_reg;

`include "typed_id_allocator_ghost_fifo_assert.svh"

    `TIA_ASSERT(a_total_range, total_reg <= CNT_W'(MAX_INSTANCES), "active total out of range")
    `TIA_ASSERT(a_fill_range, fill_reg[t_reg] <= FILL_W'(GHOST_DEPTH), "ghost fill overflow")
    `TIA_ASSERT(a_peak_mono, peak_reg >= $past(peak_reg), "peak decreased")
    `TIA_ASSERT_IMPL(a_out_from_done, $rose(out_valid_reg), $past(state_reg == S_DONE),
        "result without finished transaction")

endmodule

`default_nettype wire
